/* rtl/bust_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bust_pkg
// Shared types, field layout and defaults for the bounded unordered set table.
// ---------------------------------------------------------------------------
package bust_pkg;

    // Default sizes of the table
    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    // Fixed widths of the stream fields
    localparam int CMD_W   = 2;
    localparam int ITEM_W  = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;
    localparam int CAP_W   = 5;

    // Input beat layout, lowest bit first
    localparam int IN_CMD_LSB   = 0;
    localparam int IN_ITEM_LSB  = IN_CMD_LSB + CMD_W;
    localparam int IN_INDEX_LSB = IN_ITEM_LSB + ITEM_W;
    localparam int IN_TDATA_W   = 40;

    // Output beat layout, lowest bit first
    localparam int OUT_OK_LSB    = 0;
    localparam int OUT_RD_LSB    = OUT_OK_LSB + 1;
    localparam int OUT_COUNT_LSB = OUT_RD_LSB + ITEM_W;
    localparam int OUT_EMPTY_LSB = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_TDATA_W   = 40;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_CAPACITY_ADDR = 3'd0;
    localparam logic [CAP_W-1:0]   CAPACITY_RST      = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 2'd0,
        CMD_ERASE    = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_GET      = 2'd3
    } command_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan;
        logic shift;
        logic get;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic drained;
        logic erase;
        logic out_free;
    } dp_stat_t;

endpackage

/* rtl/bust_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bust_ctrl
// Sequencer: accepts a command, steps the scan, shift or read of the table
// and hands the result to the output register.
// ---------------------------------------------------------------------------
module bust_ctrl
    import bust_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  command_t in_cmd,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_GET   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (in_cmd == CMD_GET) ? S_GET : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                    state_next = stat.erase ? S_SHIFT : S_DONE;
                else if (stat.drained)
                    state_next = S_DONE;
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (stat.drained)
                    state_next = S_DONE;
            end
            S_GET:
            begin
                cmd.get    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/bust_dp.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bust_dp
// Datapath: entry memory, item count, scan pointer with one read in flight,
// result computation and the output register.
// ---------------------------------------------------------------------------
module bust_dp
    import bust_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [CAP_W-1:0]       capacity,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [ITEM_WIDTH-1:0] mem [DEPTH];

    command_t              op_reg;
    logic [ITEM_WIDTH-1:0] item_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [CW-1:0]         held_reg;
    logic [CW-1:0]         held_next;
    logic [CW-1:0]         ptr_reg;
    logic [CW-1:0]         ptr_next;
    logic                  pend_reg;
    logic                  pend_next;
    logic [AW-1:0]         pend_pos_reg;
    logic                  found_reg;
    logic [ITEM_WIDTH-1:0] rdata_reg;

    logic                  issue;
    logic                  hit;
    logic                  drained;
    logic                  get_ok;
    logic                  ins_ok;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;
    logic                  res_ok;
    logic [ITEM_W-1:0]     res_rd;

    logic                  out_valid_reg;
    logic                  out_ok_reg;
    logic [ITEM_W-1:0]     out_rd_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic                  out_empty_reg;

    // Scan and shift read engine
    assign issue   = (cmd.scan || cmd.shift) && (ptr_reg < held_reg);
    assign hit     = cmd.scan && pend_reg && (rdata_reg == item_reg);
    assign drained = !pend_reg && (ptr_reg >= held_reg);
    assign get_ok  = 32'(index_reg) < 32'(held_reg);
    assign ins_ok  = !found_reg && (32'(held_reg) < 32'(capacity))
                     && (32'(held_reg) < 32'(DEPTH));

    assign rd_en   = issue || (cmd.get && get_ok);
    assign rd_addr = cmd.get ? AW'(index_reg) : AW'(ptr_reg);

    always_comb
    begin
        ptr_next  = ptr_reg;
        pend_next = pend_reg;
        if (cmd.accept)
        begin
            ptr_next  = '0;
            pend_next = 1'b0;
        end
        else if (hit)
        begin
            // restart after the match for the order-keeping shift
            ptr_next  = CW'(pend_pos_reg) + CW'(1);
            pend_next = 1'b0;
        end
        else if (cmd.scan || cmd.shift)
        begin
            pend_next = issue;
            if (issue)
                ptr_next = ptr_reg + CW'(1);
        end
    end

    // Write port: shift an entry down, or append on insert
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'(held_reg);
        wr_data = item_reg;
        if (cmd.shift && pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_pos_reg - AW'(1);
            wr_data = rdata_reg;
        end
        else if (cmd.finish && op_reg == CMD_INSERT && ins_ok)
        begin
            wr_en = 1'b1;
        end
    end

    // Result and new count
    always_comb
    begin
        res_ok    = 1'b0;
        res_rd    = '0;
        held_next = held_reg;
        case (op_reg)
            CMD_INSERT:
            begin
                res_ok = ins_ok;
                if (ins_ok)
                    held_next = held_reg + CW'(1);
            end
            CMD_ERASE:
            begin
                res_ok = found_reg;
                if (found_reg)
                    held_next = held_reg - CW'(1);
            end
            CMD_CONTAINS:
            begin
                res_ok = found_reg;
            end
            default:
            begin
                res_ok = get_ok;
                if (get_ok)
                    res_rd = ITEM_W'(rdata_reg);
            end
        endcase
    end

    // Entry memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // Latch the command and track the read in flight
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= command_t'(s_tdata[IN_CMD_LSB +: CMD_W]);
            item_reg  <= ITEM_WIDTH'(s_tdata[IN_ITEM_LSB +: ITEM_W]);
            index_reg <= s_tdata[IN_INDEX_LSB +: INDEX_W];
        end
        if (issue)
            pend_pos_reg <= AW'(ptr_reg);
        if (cmd.finish)
        begin
            out_ok_reg    <= res_ok;
            out_rd_reg    <= res_rd;
            out_count_reg <= COUNT_W'(held_next);
            out_empty_reg <= (held_next == '0);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            pend_reg <= pend_next;
            if (cmd.accept)
                found_reg <= 1'b0;
            else if (hit)
                found_reg <= 1'b1;
            if (cmd.finish)
                held_reg <= held_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.hit      = hit;
    assign stat.drained  = drained;
    assign stat.erase    = (op_reg == CMD_ERASE);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_empty_reg, out_count_reg, out_rd_reg, out_ok_reg};

    // Checks
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(held_reg) <= 32'(DEPTH))
        else $error("item count above table depth");

    a_held_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.finish |=> $stable(held_reg))
        else $error("item count moved outside result step");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> !wr_en)
        else $error("table written during scan");

    a_shift_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && cmd.shift) |-> (32'(wr_addr) + 1 < 32'(held_reg)))
        else $error("shift writes outside held entries");

endmodule

/* rtl/bounded_unordered_set_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_unordered_set_table
// Set of distinct items kept packed in a table, with insert, erase,
// contains and get-by-index commands and a capacity register.
// ---------------------------------------------------------------------------
// Usage:
//   One command beat on the s_ side gives one result beat on the m_ side.
//   s_tdata carries command, item and index; m_tdata carries ok, read_item,
//   count and is_empty. Capacity is to be written over the APB port at
//   offset 0 only while the block is idle; the block does not enforce this.
//   It resets to 16, and its effect saturates at DEPTH. One command is
//   worked at a time. The entry memory has one read and one write port and
//   is scanned one entry per cycle, so insert, contains and erase (scan,
//   then shift down) take longer the more items are held; get does not scan.
//   The result lands in an output register; the next command is taken
//   while it waits. If the receiver stalls, a finished result waits in the
//   sequencer until the output register frees.
//   Reset empties the set and clears the output; entries are not cleared.
// ---------------------------------------------------------------------------
module bounded_unordered_set_table
    import bust_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[1:0], item[33:2], index[37:34]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // ok[0], read_item[32:1], count[37:33],
                                              // is_empty[38]
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_wr;
    dp_cmd_t          cmd;
    dp_stat_t         stat;

    // Capacity register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_CAPACITY_ADDR);
    assign prdata = (paddr == REG_CAPACITY_ADDR) ? PDATA_W'(capacity_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAPACITY_RST;
        else if (cfg_wr)
            capacity_reg <= pwdata[CAP_W-1:0];
    end

    bust_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (command_t'(s_tdata[IN_CMD_LSB +: CMD_W])),
        .cmd      (cmd),
        .stat     (stat)
    );

    bust_dp #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .capacity (capacity_reg),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* test/bust_set_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bust_set_checker
// Watches the command, result and register ports of the set table, keeps
// its own copy of the set and the capacity, predicts each result beat and
// compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module bust_set_checker
    import bust_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // command[1:0], item[33:2], index[37:34]
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,   // ok[0], read_item[32:1], count[37:33],
                                              // is_empty[38]
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    input  logic                   pready,
    output int unsigned            outstanding,
    output int unsigned            fail_count
);

    typedef struct packed {
        logic               ok;
        logic [ITEM_W-1:0]  read_item;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } set_result_t;

    // Shadow copy of the set and the capacity register
    logic [ITEM_W-1:0] slots [DEPTH_DEF];
    int unsigned       held_q;
    logic [CAP_W-1:0]  cap_q;

    // Results predicted but not yet returned, oldest first
    set_result_t awaited [$];

    set_result_t seen;
    int unsigned bad_now;

    // Apply one command to the shadow set and return its result
    function automatic set_result_t run_set_command(command_t cmd, logic [ITEM_W-1:0] item,
                                                    logic [INDEX_W-1:0] idx);
        set_result_t res;
        int          pos;
        int unsigned limit;
        int unsigned k;
        res = '0;
        pos = -1;
        for (k = 0; k < held_q; k++)
        begin
            if (pos < 0 && slots[k] == item)
                pos = k;
        end
        // capacity saturates at the table depth
        limit = (cap_q > DEPTH_DEF) ? DEPTH_DEF : cap_q;
        case (cmd)
            CMD_INSERT:
            begin
                if (held_q < limit && pos < 0)
                begin
                    slots[held_q] = item;
                    held_q++;
                    res.ok = 1'b1;
                end
            end
            CMD_ERASE:
            begin
                if (pos >= 0)
                begin
                    // close the gap, keeping the order of later entries
                    for (k = pos; k + 1 < held_q; k++)
                        slots[k] = slots[k + 1];
                    held_q--;
                    res.ok = 1'b1;
                end
            end
            CMD_CONTAINS:
                res.ok = (pos >= 0);
            default:
            begin
                if (idx < held_q)
                begin
                    res.ok        = 1'b1;
                    res.read_item = slots[idx];
                end
            end
        endcase
        res.count    = held_q[COUNT_W-1:0];
        res.is_empty = (held_q == 0);
        return res;
    endfunction

    // Report each differing field; return how many differ
    function automatic int unsigned check_fields(set_result_t want, set_result_t got);
        int unsigned n;
        n = 0;
        if (got.ok !== want.ok)
        begin
            $error("ok: expected %0d, got %0d", want.ok, got.ok);
            n++;
        end
        if (got.read_item !== want.read_item)
        begin
            $error("read_item: expected %h, got %h", want.read_item, got.read_item);
            n++;
        end
        if (got.count !== want.count)
        begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            n++;
        end
        if (got.is_empty !== want.is_empty)
        begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            n++;
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_q = 0;
            cap_q  = CAPACITY_RST;
            awaited.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end
        else
        begin
            bad_now = 0;

            // track capacity writes
            if (psel && penable && pwrite && pready && paddr == REG_CAPACITY_ADDR)
                cap_q = pwdata[CAP_W-1:0];

            // compare a returned result beat with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                seen.ok        = m_tdata[OUT_OK_LSB];
                seen.read_item = m_tdata[OUT_RD_LSB +: ITEM_W];
                seen.count     = m_tdata[OUT_COUNT_LSB +: COUNT_W];
                seen.is_empty  = m_tdata[OUT_EMPTY_LSB];
                if (awaited.size() == 0)
                begin
                    $error("result beat with no command waiting: %h", m_tdata);
                    bad_now++;
                end
                else
                    bad_now += check_fields(awaited.pop_front(), seen);
            end

            // predict the result of an accepted command beat
            if (s_tvalid && s_tready)
                awaited.push_back(run_set_command(command_t'(s_tdata[IN_CMD_LSB +: CMD_W]),
                                                  s_tdata[IN_ITEM_LSB +: ITEM_W],
                                                  s_tdata[IN_INDEX_LSB +: INDEX_W]));

            outstanding <= awaited.size();
            fail_count  <= fail_count + bad_now;
        end
    end

endmodule

/* test/bounded_unordered_set_table_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_unordered_set_table_tb
// Drives the set table with directed and random commands under several
// capacity settings, with random gaps on the command side and random stalls
// on the result side; a checker beside the block predicts every result.
// ---------------------------------------------------------------------------
module bounded_unordered_set_table_tb;
    import bust_pkg::*;

    localparam int POOL_N      = 24;
    localparam int PHASE_ITEMS = 130;
    localparam int CYCLE_LIMIT = 600000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // command[1:0], item[33:2], index[37:34]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // ok[0], read_item[32:1], count[37:33], is_empty[38]
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int unsigned       outstanding;
    int unsigned       fail_count;
    int unsigned       cycle_count = 0;
    logic              idle_on;
    logic [ITEM_W-1:0] item_pool [POOL_N];
    logic [CAP_W:0]    phase_caps [8] = '{6'd31, 6'd1, 6'd16, 6'd0, 6'd5, 6'd16, 6'd2, 6'd16};

    bounded_unordered_set_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    bust_set_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bounded_unordered_set_table regression: fail");
            $finish;
        end
    end

    // Stall the result side in random bursts
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Send one command beat, with an optional gap before it
    task automatic issue(command_t cmd, logic [ITEM_W-1:0] item, logic [INDEX_W-1:0] idx);
        logic [IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[IN_CMD_LSB +: CMD_W]     = cmd;
        beat[IN_ITEM_LSB +: ITEM_W]   = item;
        beat[IN_INDEX_LSB +: INDEX_W] = idx;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic write_capacity(logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly items from a small pool so that hits are common
    function automatic logic [ITEM_W-1:0] pick_item();
        if ($urandom_range(0, 99) < 85)
            return item_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom();
    endfunction

    task automatic random_command();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            issue(CMD_INSERT, pick_item(), INDEX_W'($urandom_range(0, 15)));
        else if (r < 6)
            issue(CMD_ERASE, pick_item(), INDEX_W'($urandom_range(0, 15)));
        else if (r < 8)
            issue(CMD_CONTAINS, pick_item(), INDEX_W'($urandom_range(0, 15)));
        else
            issue(CMD_GET, $urandom(), INDEX_W'($urandom_range(0, 15)));
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        idle_on  <= 1'b1;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        for (int i = 0; i < POOL_N; i++)
            item_pool[i] = $urandom();
        item_pool[0] = '0;
        item_pool[1] = '1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, extreme values, duplicates, gets in and out of range
        issue(CMD_GET, $urandom(), 4'd0);
        issue(CMD_ERASE, 32'h0000_0005, 4'd0);
        issue(CMD_CONTAINS, 32'h0000_0000, 4'd15);
        issue(CMD_INSERT, 32'h0000_0000, 4'd15);
        issue(CMD_INSERT, 32'hFFFF_FFFF, 4'd0);
        issue(CMD_INSERT, 32'h0000_0000, 4'd0);
        issue(CMD_CONTAINS, 32'hFFFF_FFFF, 4'd0);
        issue(CMD_CONTAINS, 32'h1234_5678, 4'd0);
        issue(CMD_INSERT, 32'hA5A5_A5A5, 4'd0);
        issue(CMD_INSERT, 32'h5A5A_5A5A, 4'd0);
        issue(CMD_GET, $urandom(), 4'd0);
        issue(CMD_GET, $urandom(), 4'd3);
        issue(CMD_GET, $urandom(), 4'd4);
        issue(CMD_GET, $urandom(), 4'd15);
        // erase from the middle, then from the end
        issue(CMD_ERASE, 32'hFFFF_FFFF, 4'd0);
        issue(CMD_GET, $urandom(), 4'd1);
        issue(CMD_ERASE, 32'h5A5A_5A5A, 4'd0);
        wait_drained();

        // capacity lowered below the count
        write_capacity(32'd1);
        issue(CMD_INSERT, 32'h0000_0077, 4'd0);
        issue(CMD_ERASE, 32'h0000_0000, 4'd0);
        issue(CMD_INSERT, 32'h0000_0077, 4'd0);
        issue(CMD_ERASE, 32'hA5A5_A5A5, 4'd0);
        issue(CMD_INSERT, 32'h0000_0077, 4'd0);
        issue(CMD_INSERT, 32'h0000_0088, 4'd0);
        wait_drained();

        // capacity zero refuses every insert
        write_capacity(32'd0);
        issue(CMD_INSERT, 32'h0000_0099, 4'd0);
        issue(CMD_GET, $urandom(), 4'd0);
        wait_drained();

        // random phases, one capacity each; the last runs without gaps
        foreach (phase_caps[p])
        begin
            write_capacity(PDATA_W'(phase_caps[p]));
            if (p == $size(phase_caps) - 1)
                idle_on <= 1'b0;
            repeat (PHASE_ITEMS) random_command();
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("bounded_unordered_set_table regression: pass");
        else
            $display("bounded_unordered_set_table regression: fail");
        $finish;
    end

endmodule
